// File: hw/rtl/gsa_pkg.sv
// shared constants and types of the generational slot allocator
package gsa_pkg;

	localparam int SLOTS_DEF = 256;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_CHECK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	localparam logic [31:0] GEN_RESET = 32'd1;

	typedef struct packed {
		logic live_we;
		logic live_wd;
		logic gen_we;
		logic link_we;
	} gsa_wr_t;

endpackage

// File: hw/rtl/gsa_slot_mem.sv
// per-slot link, generation and live memories with write-to-read bypass
module gsa_slot_mem
	import gsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(SLOTS)-1:0]   ra,
	input  logic [$clog2(SLOTS)-1:0]   wa,
	input  gsa_wr_t                    wr,
	input  logic [31:0]                gen_wd,
	input  logic [$clog2(SLOTS):0]     link_wd,
	output logic [$clog2(SLOTS):0]     rd_link,
	output logic [31:0]                rd_gen,
	output logic                       rd_live
);

	localparam int AW = $clog2(SLOTS);
	localparam int HW = AW + 1;

	logic [HW-1:0] link_mem [SLOTS];
	logic [31:0]   gen_mem  [SLOTS];
	logic          live_mem [SLOTS];

	logic [HW-1:0] link_rd_q;
	logic [31:0]   gen_rd_q;
	logic          live_rd_q;

	logic          link_byp_q, gen_byp_q, live_byp_q;
	logic [HW-1:0] link_bd_q;
	logic [31:0]   gen_bd_q;
	logic          live_bd_q;

	always_ff @(posedge clk) begin
		if (wr.link_we) begin
			link_mem[wa] <= link_wd;
		end
		if (wr.gen_we) begin
			gen_mem[wa] <= gen_wd;
		end
		if (wr.live_we) begin
			live_mem[wa] <= wr.live_wd;
		end
		link_rd_q <= link_mem[ra];
		gen_rd_q  <= gen_mem[ra];
		live_rd_q <= live_mem[ra];
		link_bd_q <= link_wd;
		gen_bd_q  <= gen_wd;
		live_bd_q <= wr.live_wd;
	end

	// a read colliding with the write of the same edge takes the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_byp_q <= 1'b0;
			gen_byp_q  <= 1'b0;
			live_byp_q <= 1'b0;
		end else begin
			link_byp_q <= wr.link_we && (wa == ra);
			gen_byp_q  <= wr.gen_we && (wa == ra);
			live_byp_q <= wr.live_we && (wa == ra);
		end
	end

	assign rd_link = link_byp_q ? link_bd_q : link_rd_q;
	assign rd_gen  = gen_byp_q ? gen_bd_q : gen_rd_q;
	assign rd_live = live_byp_q ? live_bd_q : live_rd_q;

endmodule

// File: hw/rtl/gsa_exec.sv
// decision logic for one command: result, memory writes, next head and fill mark
module gsa_exec
	import gsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                       vld,
	input  logic [1:0]                 func,
	input  logic [7:0]                 idx,
	input  logic [31:0]                hgen,
	input  logic [$clog2(SLOTS):0]     head_q,
	input  logic [$clog2(SLOTS):0]     hw_q,
	input  logic [$clog2(SLOTS):0]     rd_link,
	input  logic [31:0]                rd_gen,
	input  logic                       rd_live,
	output logic [7:0]                 res_index,
	output logic [31:0]                res_gen,
	output logic [1:0]                 res_status,
	output gsa_wr_t                    wr,
	output logic [$clog2(SLOTS)-1:0]   wa,
	output logic [31:0]                gen_wd,
	output logic [$clog2(SLOTS):0]     link_wd,
	output logic [$clog2(SLOTS):0]     head_d,
	output logic [$clog2(SLOTS):0]     hw_d
);

	localparam int AW = $clog2(SLOTS);
	localparam int HW = AW + 1;
	localparam int CW = (HW > 9) ? HW : 9;
	localparam logic [HW-1:0] END_MARK = HW'(SLOTS);
	localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

	logic          is_alloc;
	logic [CW-1:0] key;
	logic          never;
	logic [31:0]   gen_cur;
	logic          live_cur;
	logic [HW-1:0] link_cur;

	assign is_alloc = (func == FUNC_ALLOC);
	assign key      = is_alloc ? CW'(head_q) : CW'(idx);

	// slots at or above the fill mark were never handed out and keep reset values
	assign never    = key >= CW'(hw_q);
	assign gen_cur  = never ? GEN_RESET : rd_gen;
	assign live_cur = never ? 1'b0 : rd_live;
	assign link_cur = never ? (head_q + HW'(1)) : rd_link;

	always_comb begin
		res_index  = idx;
		res_gen    = '0;
		res_status = ST_OK;
		wr         = '0;
		wa         = AW'(idx);
		gen_wd     = gen_cur;
		link_wd    = head_q;
		head_d     = head_q;
		hw_d       = hw_q;
		if (vld) begin
			case (func)
				FUNC_ALLOC: begin
					wa = head_q[AW-1:0];
					if (head_q == END_MARK) begin
						res_index  = '0;
						res_status = ST_EMPTY;
					end else begin
						res_index  = 8'(head_q);
						res_gen    = gen_cur;
						wr.live_we = 1'b1;
						wr.live_wd = 1'b1;
						wr.gen_we  = 1'b1;
						head_d     = link_cur;
						if (never) begin
							hw_d = hw_q + HW'(1);
						end
					end
				end
				default: begin
					if (key >= SLOTS_C) begin
						res_status = ST_STALE;
					end else if (!live_cur || gen_cur != hgen) begin
						res_gen    = gen_cur;
						res_status = ST_STALE;
					end else if (func == FUNC_FREE) begin
						gen_wd     = gen_cur + 32'd1;
						res_gen    = gen_cur + 32'd1;
						wr.gen_we  = 1'b1;
						wr.live_we = 1'b1;
						wr.live_wd = 1'b0;
						wr.link_we = 1'b1;
						head_d     = HW'(idx);
					end else begin
						res_gen = gen_cur;
					end
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/generational_slot_allocator_unit.sv
// result path: start is registered into the s1 stage, then done strobes with the result from the output registers
// throughput: one command per cycle, busy never rises; memory bypass feeds back-to-back words
// reset: head at slot 0, all generations 1, nothing live, taken at once through a fill mark
// no clearing pass follows reset; the receiver cannot stall and done lasts one cycle
// top level of the generational slot allocator
module generational_slot_allocator_unit
	import gsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  handle_index,
	input  logic [31:0] handle_generation,
	output logic        done,
	output logic [7:0]  slot_index,
	output logic [31:0] slot_generation,
	output logic [1:0]  status
);

	localparam int AW = $clog2(SLOTS);
	localparam int HW = AW + 1;

	logic          vld_s1;
	logic [1:0]    func_s1;
	logic [7:0]    idx_s1;
	logic [31:0]   hgen_s1;

	logic [HW-1:0] head_q, hw_q, head_d, hw_d;
	logic [AW-1:0] ra, wa;
	gsa_wr_t       wr;
	logic [31:0]   gen_wd, rd_gen;
	logic [HW-1:0] link_wd, rd_link;
	logic          rd_live;

	logic [7:0]    res_index;
	logic [31:0]   res_gen;
	logic [1:0]    res_status;

	logic          done_q;
	logic [7:0]    slot_index_q;
	logic [31:0]   slot_generation_q;
	logic [1:0]    status_q;

	assign busy = 1'b0;

	// an allocate reads at the head left by the command in flight
	assign ra = (func == FUNC_ALLOC) ? head_d[AW-1:0] : AW'(handle_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			head_q <= '0;
			hw_q   <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			head_q <= head_d;
			hw_q   <= hw_d;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1 <= func;
			idx_s1  <= handle_index;
			hgen_s1 <= handle_generation;
		end
		if (vld_s1) begin
			slot_index_q      <= res_index;
			slot_generation_q <= res_gen;
			status_q          <= res_status;
		end
	end

	gsa_slot_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra      (ra),
		.wa      (wa),
		.wr      (wr),
		.gen_wd  (gen_wd),
		.link_wd (link_wd),
		.rd_link (rd_link),
		.rd_gen  (rd_gen),
		.rd_live (rd_live)
	);

	gsa_exec #(
		.SLOTS(SLOTS)
	) u_exec (
		.vld        (vld_s1),
		.func       (func_s1),
		.idx        (idx_s1),
		.hgen       (hgen_s1),
		.head_q     (head_q),
		.hw_q       (hw_q),
		.rd_link    (rd_link),
		.rd_gen     (rd_gen),
		.rd_live    (rd_live),
		.res_index  (res_index),
		.res_gen    (res_gen),
		.res_status (res_status),
		.wr         (wr),
		.wa         (wa),
		.gen_wd     (gen_wd),
		.link_wd    (link_wd),
		.head_d     (head_d),
		.hw_d       (hw_d)
	);

	assign done            = done_q;
	assign slot_index      = slot_index_q;
	assign slot_generation = slot_generation_q;
	assign status          = status_q;

endmodule
